@@ src/bfr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfr_pkg
// Shared constants, codes and types of the buffer frame replacement block.
// ----------------------------------------------------------------------------
package bfr_pkg;

   localparam int DEF_FRAMES    = 16;
   localparam int DEF_PAGE_BITS = 32;
   localparam int DEF_PIN_BITS  = 16;

   localparam int CSR_DATA_W = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CNT_W      = 32;

   localparam logic [CSR_IDX_W-1:0] CFG_POLICY = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CFG_FRAMES = 1'd1;

   localparam logic       POLICY_FIFO = 1'b0;
   localparam logic       POLICY_LRU  = 1'b1;
   localparam logic [4:0] FRAMES_RESET = 5'd16;

   localparam logic [1:0] OP_PIN   = 2'd0;
   localparam logic [1:0] OP_UNPIN = 2'd1;
   localparam logic [1:0] OP_DIRTY = 2'd2;
   localparam logic [1:0] OP_FLUSH = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_ABSENT  = 2'd1;
   localparam logic [1:0] ST_NO_FREE = 2'd2;

   localparam logic [1:0] ACT_NONE  = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_WRITE = 2'd2;

   // request class decoded at the front
   typedef struct packed {
      logic is_pin;
      logic is_unpin;
      logic is_dirty;
      logic is_flush;
   } req_kind_type;

endpackage

@@ src/bfr_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfr_front
// Accept requests, decode the operation and hold them in a two-entry queue.
// ----------------------------------------------------------------------------
module bfr_front import bfr_pkg::*; #(
   parameter int PAGE_BITS = DEF_PAGE_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [1:0]           in_op,
   input  logic [PAGE_BITS-1:0] in_page,
   output logic                 q_valid,
   input  logic                 q_ready,
   output req_kind_type         q_kind,
   output logic [PAGE_BITS-1:0] q_page
);

   req_kind_type         kind_ff [2];
   logic [PAGE_BITS-1:0] page_ff [2];
   logic                 wr_ptr_ff, wr_ptr_in;
   logic                 rd_ptr_ff, rd_ptr_in;
   logic [1:0]           count_ff, count_in;
   logic                 push, pop;
   req_kind_type         kind_dec;

   always_comb begin
      kind_dec = '0;
      unique case (in_op)
         OP_PIN:   kind_dec.is_pin   = 1'b1;
         OP_UNPIN: kind_dec.is_unpin = 1'b1;
         OP_DIRTY: kind_dec.is_dirty = 1'b1;
         default:  kind_dec.is_flush = 1'b1;
      endcase
   end

   assign in_ready = (count_ff != 2'd2);
   assign q_valid  = (count_ff != 2'd0);
   assign push     = in_valid && in_ready;
   assign pop      = q_valid && q_ready;
   assign q_kind   = kind_ff[rd_ptr_ff];
   assign q_page   = page_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         kind_ff[wr_ptr_ff] <= kind_dec;
         page_ff[wr_ptr_ff] <= in_page;
      end
   end

endmodule

@@ src/bfr_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfr_engine
// Carry out one queued request at a time over the frame table and emit
// its results through an output register.
// ----------------------------------------------------------------------------
module bfr_engine import bfr_pkg::*; #(
   parameter int FRAMES    = DEF_FRAMES,
   parameter int PAGE_BITS = DEF_PAGE_BITS,
   parameter int PIN_BITS  = DEF_PIN_BITS,
   localparam int FB = $clog2(FRAMES),
   localparam int CW = FB + 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  q_valid,
   output logic                  q_ready,
   input  req_kind_type          q_kind,
   input  logic [PAGE_BITS-1:0]  q_page,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [1:0]            out_status,
   output logic [1:0]            out_action,
   output logic [FB-1:0]         out_frame,
   output logic [PAGE_BITS-1:0]  out_page,
   output logic [PIN_BITS-1:0]   out_pins,
   output logic                  out_hit,
   output logic                  out_last,
   output logic [CNT_W-1:0]      out_reads,
   output logic [CNT_W-1:0]      out_writes
);

   localparam logic [PIN_BITS-1:0] PIN_MAX = '1;

   typedef enum logic [10:0] {
      S_IDLE   = 11'b00000000001,
      S_SCAN   = 11'b00000000010,
      S_DECIDE = 11'b00000000100,
      S_VICTIM = 11'b00000001000,
      S_NOFREE = 11'b00000010000,
      S_EVICT  = 11'b00000100000,
      S_FILL   = 11'b00001000000,
      S_RFIND  = 11'b00010000000,
      S_RSHIFT = 11'b00100000000,
      S_FLUSH  = 11'b01000000000,
      S_FDONE  = 11'b10000000000
   } state_type;

   // frame table
   logic [PAGE_BITS-1:0] tag_ff   [FRAMES];
   logic [PIN_BITS-1:0]  pins_ff  [FRAMES];
   logic [FRAMES-1:0]    valid_ff;
   logic [FRAMES-1:0]    dirty_ff;
   logic [FB-1:0]        rec_ff   [FRAMES];
   logic [FB-1:0]        front_ff, front_in;

   logic                 policy_ff;
   logic [4:0]           fiu_ff;
   logic [CNT_W-1:0]     reads_ff, writes_ff;

   state_type            state_ff, state_in;
   req_kind_type         kind_ff, kind_in;
   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic [FB-1:0]        idx_ff, idx_in;
   logic [FB-1:0]        cnt_ff, cnt_in;
   logic [FB-1:0]        frame_ff, frame_in;
   logic [FB-1:0]        free_idx_ff, free_idx_in;
   logic                 hit_ff, hit_in;
   logic                 free_ff, free_in;
   logic                 mk_ff, mk_in;

   // output register
   logic                 ovalid_ff;
   logic [1:0]           ostatus_ff, oaction_ff;
   logic [FB-1:0]        oframe_ff;
   logic [PAGE_BITS-1:0] opage_ff;
   logic [PIN_BITS-1:0]  opins_ff;
   logic                 ohit_ff, olast_ff;
   logic [CNT_W-1:0]     oreads_ff, owrites_ff;

   // strobes and emitted fields
   logic                 emit;
   logic [1:0]           e_status, e_action;
   logic [FB-1:0]        e_frame;
   logic [PAGE_BITS-1:0] e_page;
   logic [PIN_BITS-1:0]  e_pins;
   logic                 e_hit, e_last;
   logic                 rd_inc, wr_inc;
   logic                 pins_we, dirty_we, dirty_wd, fill_we, rec_shift;
   logic [PIN_BITS-1:0]  pins_wd;

   logic                 out_free;
   logic [FB-1:0]        sel;
   logic [PAGE_BITS-1:0] tag_rd;
   logic [PIN_BITS-1:0]  pins_rd;
   logic                 valid_rd, dirty_rd;
   logic [31:0]          fiu32, pool32;
   logic [CW-1:0]        pool, pool_m1;
   logic [CW-1:0]        next_wrap;
   logic                 last_idx;
   logic [CNT_W-1:0]     reads_nx, writes_nx;

   always_comb begin
      fiu32  = {27'd0, fiu_ff};
      pool32 = (fiu32 == 32'd0) ? 32'd1 :
               ((fiu32 > FRAMES) ? 32'(FRAMES) : fiu32);
      pool    = pool32[CW-1:0];
      pool_m1 = pool - CW'(1);
   end

   assign out_free = !ovalid_ff || out_ready;
   assign last_idx = ({1'b0, idx_ff} == pool_m1);

   always_comb begin
      unique case (state_ff)
         S_SCAN, S_FLUSH: sel = idx_ff;
         S_VICTIM:        sel = (policy_ff == POLICY_LRU) ? rec_ff[idx_ff] : idx_ff;
         default:         sel = frame_ff;
      endcase
   end

   assign tag_rd   = tag_ff[sel];
   assign pins_rd  = pins_ff[sel];
   assign valid_rd = valid_ff[sel];
   assign dirty_rd = dirty_ff[sel];
   assign next_wrap = ({1'b0, sel} + CW'(1) >= pool) ? CW'(0) : ({1'b0, sel} + CW'(1));

   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      page_in     = page_ff;
      idx_in      = idx_ff;
      cnt_in      = cnt_ff;
      frame_in    = frame_ff;
      free_idx_in = free_idx_ff;
      hit_in      = hit_ff;
      free_in     = free_ff;
      mk_in       = mk_ff;
      front_in    = front_ff;
      q_ready     = 1'b0;
      emit        = 1'b0;
      e_status    = ST_OK;
      e_action    = ACT_NONE;
      e_frame     = '0;
      e_page      = '0;
      e_pins      = '0;
      e_hit       = 1'b0;
      e_last      = 1'b1;
      rd_inc      = 1'b0;
      wr_inc      = 1'b0;
      pins_we     = 1'b0;
      pins_wd     = pins_rd;
      dirty_we    = 1'b0;
      dirty_wd    = 1'b0;
      fill_we     = 1'b0;
      rec_shift   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            q_ready = 1'b1;
            if (q_valid) begin
               kind_in = q_kind;
               page_in = q_page;
               idx_in  = '0;
               hit_in  = 1'b0;
               free_in = 1'b0;
               mk_in   = 1'b0;
               state_in = q_kind.is_flush ? S_FLUSH : S_SCAN;
            end
         end
         S_SCAN: begin
            // first matching frame and first free frame of the pool
            if (valid_rd && tag_rd == page_ff && !hit_ff) begin
               hit_in   = 1'b1;
               frame_in = sel;
            end
            if (!valid_rd && !free_ff) begin
               free_in     = 1'b1;
               free_idx_in = sel;
            end
            if (last_idx) state_in = S_DECIDE;
            else idx_in = idx_ff + FB'(1);
         end
         S_DECIDE: begin
            if (kind_ff.is_pin && !hit_ff) begin
               if (free_ff) begin
                  frame_in = free_idx_ff;
                  state_in = S_FILL;
               end else begin
                  cnt_in   = '0;
                  idx_in   = (policy_ff == POLICY_LRU) ? '0 :
                             (({1'b0, front_ff} >= pool) ? '0 : front_ff);
                  state_in = S_VICTIM;
               end
            end else if (out_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
               if (!hit_ff) begin
                  e_status = ST_ABSENT;
                  e_page   = page_ff;
               end else if (kind_ff.is_pin) begin
                  pins_we  = 1'b1;
                  pins_wd  = (pins_rd == PIN_MAX) ? pins_rd : pins_rd + PIN_BITS'(1);
                  e_frame  = frame_ff;
                  e_page   = page_ff;
                  e_pins   = pins_wd;
                  e_hit    = 1'b1;
                  mk_in    = policy_ff;
               end else if (kind_ff.is_unpin) begin
                  pins_we  = 1'b1;
                  pins_wd  = (pins_rd != '0) ? pins_rd - PIN_BITS'(1) : pins_rd;
                  if (pins_rd == PIN_BITS'(1) && dirty_rd) begin
                     dirty_we = 1'b1;
                     wr_inc   = 1'b1;
                     e_action = ACT_WRITE;
                  end
                  e_frame = frame_ff;
                  e_page  = tag_rd;
                  e_pins  = pins_wd;
                  mk_in   = policy_ff && !free_ff;
               end else begin
                  dirty_we = 1'b1;
                  dirty_wd = 1'b1;
                  e_frame  = frame_ff;
                  e_page   = page_ff;
                  e_pins   = pins_rd;
               end
               if (mk_in) begin
                  idx_in   = '0;
                  state_in = S_RFIND;
               end
            end
         end
         S_VICTIM: begin
            if (policy_ff == POLICY_FIFO) begin
               if (valid_rd && pins_rd == '0) begin
                  frame_in = sel;
                  front_in = next_wrap[FB-1:0];
                  state_in = S_EVICT;
               end else if ({1'b0, cnt_ff} == pool_m1) begin
                  state_in = S_NOFREE;
               end else begin
                  cnt_in = cnt_ff + FB'(1);
                  idx_in = next_wrap[FB-1:0];
               end
            end else begin
               if ({1'b0, sel} < pool && valid_rd && pins_rd == '0) begin
                  frame_in = sel;
                  state_in = S_EVICT;
               end else if (idx_ff == FB'(FRAMES - 1)) begin
                  state_in = S_NOFREE;
               end else begin
                  idx_in = idx_ff + FB'(1);
               end
            end
         end
         S_NOFREE: begin
            if (out_free) begin
               emit     = 1'b1;
               e_status = ST_NO_FREE;
               e_page   = page_ff;
               state_in = S_IDLE;
            end
         end
         S_EVICT: begin
            // write back the old page of a dirty victim
            if (!dirty_rd) begin
               state_in = S_FILL;
            end else if (out_free) begin
               emit     = 1'b1;
               wr_inc   = 1'b1;
               e_action = ACT_WRITE;
               e_frame  = frame_ff;
               e_page   = tag_rd;
               e_last   = 1'b0;
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            if (out_free) begin
               fill_we  = 1'b1;
               rd_inc   = 1'b1;
               emit     = 1'b1;
               e_action = ACT_READ;
               e_frame  = frame_ff;
               e_page   = page_ff;
               e_pins   = PIN_BITS'(1);
               mk_in    = policy_ff;
               idx_in   = '0;
               state_in = policy_ff ? S_RFIND : S_IDLE;
            end
         end
         S_RFIND: begin
            if (rec_ff[idx_ff] == frame_ff) state_in = S_RSHIFT;
            else idx_in = idx_ff + FB'(1);
         end
         S_RSHIFT: begin
            rec_shift = 1'b1;
            state_in  = S_IDLE;
         end
         S_FLUSH: begin
            if (valid_rd && dirty_rd && pins_rd == '0) begin
               if (out_free) begin
                  emit     = 1'b1;
                  dirty_we = 1'b1;
                  wr_inc   = 1'b1;
                  e_action = ACT_WRITE;
                  e_frame  = sel;
                  e_page   = tag_rd;
                  e_last   = 1'b0;
                  if (last_idx) state_in = S_FDONE;
                  else idx_in = idx_ff + FB'(1);
               end
            end else if (last_idx) begin
               state_in = S_FDONE;
            end else begin
               idx_in = idx_ff + FB'(1);
            end
         end
         S_FDONE: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign reads_nx  = reads_ff + CNT_W'(rd_inc);
   assign writes_nx = writes_ff + CNT_W'(wr_inc);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         policy_ff <= POLICY_FIFO;
         fiu_ff    <= FRAMES_RESET;
         valid_ff  <= '0;
         dirty_ff  <= '0;
         front_ff  <= '0;
         reads_ff  <= '0;
         writes_ff <= '0;
         ovalid_ff <= 1'b0;
         for (int i = 0; i < FRAMES; i++) rec_ff[i] <= FB'(i);
      end else begin
         state_ff  <= state_in;
         front_ff  <= front_in;
         reads_ff  <= reads_nx;
         writes_ff <= writes_nx;
         if (csr_wen) begin
            unique case (csr_index)
               CFG_POLICY: policy_ff <= csr_wdata[0];
               default:    fiu_ff    <= csr_wdata;
            endcase
         end
         if (fill_we) valid_ff[sel] <= 1'b1;
         if (fill_we) dirty_ff[sel] <= 1'b0;
         else if (dirty_we) dirty_ff[sel] <= dirty_wd;
         if (emit) ovalid_ff <= 1'b1;
         else if (out_ready) ovalid_ff <= 1'b0;
         if (rec_shift) begin
            // drop the frame from its place and append it as most recent
            for (int j = 0; j < FRAMES - 1; j++) begin
               if (FB'(j) >= idx_ff) rec_ff[j] <= rec_ff[j+1];
            end
            rec_ff[FRAMES-1] <= frame_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      page_ff     <= page_in;
      idx_ff      <= idx_in;
      cnt_ff      <= cnt_in;
      frame_ff    <= frame_in;
      free_idx_ff <= free_idx_in;
      hit_ff      <= hit_in;
      free_ff     <= free_in;
      mk_ff       <= mk_in;
      if (fill_we) begin
         tag_ff[sel]  <= page_ff;
         pins_ff[sel] <= PIN_BITS'(1);
      end else if (pins_we) begin
         pins_ff[sel] <= pins_wd;
      end
      if (emit) begin
         ostatus_ff <= e_status;
         oaction_ff <= e_action;
         oframe_ff  <= e_frame;
         opage_ff   <= e_page;
         opins_ff   <= e_pins;
         ohit_ff    <= e_hit;
         olast_ff   <= e_last;
         oreads_ff  <= reads_nx;
         owrites_ff <= writes_nx;
      end
   end

   assign out_valid  = ovalid_ff;
   assign out_status = ostatus_ff;
   assign out_action = oaction_ff;
   assign out_frame  = oframe_ff;
   assign out_page   = opage_ff;
   assign out_pins   = opins_ff;
   assign out_hit    = ohit_ff;
   assign out_last   = olast_ff;
   assign out_reads  = oreads_ff;
   assign out_writes = owrites_ff;

   a_shift_target: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RSHIFT |-> rec_ff[idx_ff] == frame_ff)
      else $error("recency shift does not start at the target frame");

   a_hit_in_pool: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE && hit_ff) |-> {1'b0, frame_ff} < pool)
      else $error("hit frame outside the pool");

   a_mid_is_write: assert property (@(posedge clock) disable iff (reset)
      (ovalid_ff && !olast_ff) |-> oaction_ff == ACT_WRITE)
      else $error("non-final result that is not a write-back");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("result overwrites one not yet taken");

endmodule

@@ src/buffer_frame_replacement_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buffer_frame_replacement_top
// Buffer pool frame table with FIFO or least-recently-used replacement.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Carries
//  req_     in         tvalid/tready        operation, page number
//  rsp_     out        tvalid/tready/tlast  status, action, frame, page,
//                                           pins, hit, counters
//  csr_     in         wen                  policy, frames in use
//
//  A request leaves the queue, the lookup scan visits each pool frame in turn
//  and a decide step follows; a miss with no free frame adds a victim search
//  over up to pool frames under FIFO, a write-back of a dirty victim and the
//  fill. A flush walks the pool frames. Under LRU the victim search and the
//  recency update each walk up to FRAMES entries.
//  Reset is synchronous; the table is empty and recency in index order.
//  A stalled result holds the engine; the two-entry queue keeps accepting until full.
// ----------------------------------------------------------------------------
module buffer_frame_replacement_top import bfr_pkg::*; #(
   parameter int FRAMES    = DEF_FRAMES,
   parameter int PAGE_BITS = DEF_PAGE_BITS,
   parameter int PIN_BITS  = DEF_PIN_BITS,
   localparam int FB      = $clog2(FRAMES),
   localparam int REQ_RAW = 2 + PAGE_BITS,
   localparam int REQ_W   = ((REQ_RAW + 7) / 8) * 8,
   localparam int RSP_RAW = 2 + 2 + FB + PAGE_BITS + PIN_BITS + 1 + 2 * CNT_W,
   localparam int RSP_W   = ((RSP_RAW + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // operation, page_number
   input  logic [REQ_W-1:0]      req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // status, action, frame_index, action_page, pin_count, is_hit,
   // reads_done, writes_done
   output logic [RSP_W-1:0]      rsp_tdata,
   output logic                  rsp_tlast
);

   logic                 q_valid, q_ready;
   req_kind_type         q_kind;
   logic [PAGE_BITS-1:0] q_page;
   logic [1:0]           r_status, r_action;
   logic [FB-1:0]        r_frame;
   logic [PAGE_BITS-1:0] r_page;
   logic [PIN_BITS-1:0]  r_pins;
   logic                 r_hit;
   logic [CNT_W-1:0]     r_reads, r_writes;

   // decode and queue requests
   bfr_front #(.PAGE_BITS(PAGE_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_op    (req_tdata[1:0]),
      .in_page  (req_tdata[2 +: PAGE_BITS]),
      .q_valid  (q_valid),
      .q_ready  (q_ready),
      .q_kind   (q_kind),
      .q_page   (q_page)
   );

   // walk the frame table and issue results
   bfr_engine #(
      .FRAMES    (FRAMES),
      .PAGE_BITS (PAGE_BITS),
      .PIN_BITS  (PIN_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_kind     (q_kind),
      .q_page     (q_page),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_status (r_status),
      .out_action (r_action),
      .out_frame  (r_frame),
      .out_page   (r_page),
      .out_pins   (r_pins),
      .out_hit    (r_hit),
      .out_last   (rsp_tlast),
      .out_reads  (r_reads),
      .out_writes (r_writes)
   );

   // pack result fields, lowest first, zero pad to whole bytes
   assign rsp_tdata = RSP_W'({r_writes, r_reads, r_hit, r_pins, r_page,
                              r_frame, r_action, r_status});

endmodule

@@ sim/buffer_frame_replacement_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buffer_frame_replacement_top_tb
// Self-checking bench for the buffer frame table. Requests are driven on the
// req_ stream with random gaps. A scoreboard class keeps its own copy of the
// frame table and predicts every result. Each result taken on the rsp_ stream
// is compared field by field with the oldest prediction. The pool size and
// the replacement policy are changed between phases, only while idle.
// ----------------------------------------------------------------------------
module buffer_frame_replacement_top_tb;
   import bfr_pkg::*;

   localparam int NF     = 16;
   localparam int REQ_W  = 40;
   localparam int RSP_W  = 128;
   localparam int LIMIT  = 400000;

   // one predicted result
   typedef struct packed {
      logic [1:0]  status;
      logic [1:0]  action;
      logic [3:0]  frame;
      logic [31:0] page;
      logic [15:0] pins;
      logic        hit;
      logic        last;
      logic [31:0] reads;
      logic [31:0] writes;
   } frame_rsp_type;

   class frame_table_sb;
      logic        policy;
      logic [4:0]  pool_cfg;
      logic [31:0] tag[NF];
      bit          valid[NF];
      logic [15:0] pins[NF];
      bit          dirty[NF];
      int          recency[NF];
      int          front;
      int          reads, writes;
      frame_rsp_type pending[$];
      int          errors;

      function new();
         policy = POLICY_FIFO;
         pool_cfg = FRAMES_RESET;
         for (int i = 0; i < NF; i++) begin
            tag[i] = 0; valid[i] = 0; pins[i] = 0; dirty[i] = 0; recency[i] = i;
         end
         front = 0; reads = 0; writes = 0; errors = 0;
      endfunction

      function int pool();
         if (pool_cfg < 1) return 1;
         if (pool_cfg > NF) return NF;
         return pool_cfg;
      endfunction

      function int find_page(logic [31:0] p);
         for (int i = 0; i < pool(); i++) if (valid[i] && tag[i] == p) return i;
         return -1;
      endfunction

      function int find_free();
         for (int i = 0; i < pool(); i++) if (!valid[i]) return i;
         return -1;
      endfunction

      function void touch(int f);
         int k;
         k = 0;
         while (k < NF && recency[k] != f) k++;
         for (; k + 1 < NF; k++) recency[k] = recency[k + 1];
         recency[NF - 1] = f;
      endfunction

      function void push(logic [1:0] st, logic [1:0] act, int f, logic [31:0] p,
                         logic [15:0] pc, logic h, logic l);
         frame_rsp_type r;
         r = '{st, act, f[3:0], p, pc, h, l, reads, writes};
         pending.push_back(r);
      endfunction

      function int choose_victim();
         int f, c;
         c = pool();
         if (policy == POLICY_FIFO) begin
            f = (front >= c) ? 0 : front;
            for (int n = 0; n < c; n++) begin
               if (valid[f] && pins[f] == 0) return f;
               f = (f + 1 >= c) ? 0 : f + 1;
            end
            return -1;
         end
         for (int k = 0; k < NF; k++)
            if (recency[k] < c && valid[recency[k]] && pins[recency[k]] == 0)
               return recency[k];
         return -1;
      endfunction

      // note an accepted request and predict its results
      function void note_request(logic [1:0] op, logic [31:0] p);
         int f;
         f = find_page(p);
         case (op)
            OP_PIN: begin
               if (f >= 0) begin
                  if (pins[f] != 16'hFFFF) pins[f]++;
                  if (policy == POLICY_LRU) touch(f);
                  push(ST_OK, ACT_NONE, f, p, pins[f], 1, 1);
                  return;
               end
               f = find_free();
               if (f < 0) begin
                  f = choose_victim();
                  if (f < 0) begin
                     push(ST_NO_FREE, ACT_NONE, 0, p, 0, 0, 1);
                     return;
                  end
                  if (policy == POLICY_FIFO) front = (f + 1 >= pool()) ? 0 : f + 1;
                  if (dirty[f]) begin
                     writes++;
                     push(ST_OK, ACT_WRITE, f, tag[f], 0, 0, 0);
                  end
               end
               tag[f] = p; valid[f] = 1; pins[f] = 1; dirty[f] = 0;
               if (policy == POLICY_LRU) touch(f);
               reads++;
               push(ST_OK, ACT_READ, f, p, 1, 0, 1);
            end
            OP_UNPIN: begin
               logic [1:0] act;
               bit zero;
               act = ACT_NONE; zero = 0;
               if (f < 0) begin
                  push(ST_ABSENT, ACT_NONE, 0, p, 0, 0, 1);
                  return;
               end
               if (pins[f] > 0) begin
                  pins[f]--;
                  zero = (pins[f] == 0);
               end
               if (policy == POLICY_LRU && find_free() < 0) touch(f);
               if (zero && dirty[f]) begin
                  dirty[f] = 0; writes++; act = ACT_WRITE;
               end
               push(ST_OK, act, f, tag[f], pins[f], 0, 1);
            end
            OP_DIRTY: begin
               if (f < 0) begin
                  push(ST_ABSENT, ACT_NONE, 0, p, 0, 0, 1);
                  return;
               end
               dirty[f] = 1;
               push(ST_OK, ACT_NONE, f, p, pins[f], 0, 1);
            end
            default: begin
               for (int i = 0; i < pool(); i++)
                  if (valid[i] && dirty[i] && pins[i] == 0) begin
                     dirty[i] = 0; writes++;
                     push(ST_OK, ACT_WRITE, i, tag[i], 0, 0, 0);
                  end
               push(ST_OK, ACT_NONE, 0, 0, 0, 0, 1);
            end
         endcase
      endfunction

      // compare one accepted result with the oldest prediction
      function void check_result(logic [RSP_W-1:0] d, logic l);
         frame_rsp_type e;
         if (pending.size() == 0) begin
            $error("unexpected result %h", d);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (d[1:0] !== e.status) begin
            $error("status exp %0d got %0d", e.status, d[1:0]); errors++;
         end
         if (d[3:2] !== e.action) begin
            $error("action exp %0d got %0d", e.action, d[3:2]); errors++;
         end
         if (d[7:4] !== e.frame) begin
            $error("frame_index exp %0d got %0d", e.frame, d[7:4]); errors++;
         end
         if (d[39:8] !== e.page) begin
            $error("action_page exp %h got %h", e.page, d[39:8]); errors++;
         end
         if (d[55:40] !== e.pins) begin
            $error("pin_count exp %0d got %0d", e.pins, d[55:40]); errors++;
         end
         if (d[56] !== e.hit) begin
            $error("is_hit exp %0d got %0d", e.hit, d[56]); errors++;
         end
         if (l !== e.last) begin
            $error("last exp %0d got %0d", e.last, l); errors++;
         end
         if (d[88:57] !== e.reads) begin
            $error("reads_done exp %0d got %0d", e.reads, d[88:57]); errors++;
         end
         if (d[120:89] !== e.writes) begin
            $error("writes_done exp %0d got %0d", e.writes, d[120:89]); errors++;
         end
      endfunction
   endclass

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  csr_wen = 0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_tvalid = 0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 0;
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  rsp_tlast;

   frame_table_sb sb = new();
   bit   calm;         // no idling on either side while set
   int   cycles;
   logic [31:0] page_pool[8];

   always #4 clock = ~clock;

   buffer_frame_replacement_top u_dut (
      .clock, .reset, .csr_wen, .csr_index, .csr_wdata,
      .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast
   );

   // timeout guard
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // result side: stall about one cycle in ten, check every accepted result
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tlast);
      rsp_tready <= calm || ($urandom_range(99) >= 10);
   end

   // hand one request over and predict its results; tvalid stays high
   // into the next request unless an idle cycle drops it
   task automatic send_request(logic [1:0] op, logic [31:0] p);
      while (!calm && $urandom_range(99) < 10) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {6'd0, p, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(op, p);
   endtask

   // drain, let the engine settle, then write a register
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [4:0] val);
      int n;
      n = 0;
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      while (n < 60) begin
         @(posedge clock);
         n++;
      end
      csr_wen   <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wen <= 0;
      if (idx == CFG_POLICY) sb.policy = val[0];
      else sb.pool_cfg = val;
   endtask

   // random page from a small working set, now and then a wild one
   function automatic logic [31:0] pick_page();
      if ($urandom_range(9) == 0) return $urandom();
      return page_pool[$urandom_range(7)];
   endfunction

   task automatic random_phase(int n);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 45) send_request(OP_PIN, pick_page());
         else if (r < 75) send_request(OP_UNPIN, pick_page());
         else if (r < 95) send_request(OP_DIRTY, pick_page());
         else send_request(OP_FLUSH, $urandom());
      end
   endtask

   initial begin
      cycles = 0;
      calm = 0;
      page_pool = '{32'h0, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000,
                    32'h5555_AAAA, 32'hAAAA_5555, 32'h7, 32'h1234_5678};
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: absent page, fill, hit, dirty, unpin write-back, flush
      send_request(OP_UNPIN, 32'hFFFF_FFFF);
      send_request(OP_DIRTY, 32'h0);
      send_request(OP_PIN, 32'h0);
      send_request(OP_PIN, 32'h0);
      send_request(OP_PIN, 32'hFFFF_FFFF);
      send_request(OP_DIRTY, 32'hFFFF_FFFF);
      send_request(OP_UNPIN, 32'hFFFF_FFFF);
      send_request(OP_UNPIN, 32'hFFFF_FFFF);
      send_request(OP_DIRTY, 32'h0);
      send_request(OP_FLUSH, 32'hFFFF_FFFF);

      // small pool: fill, clean victim eviction, all pinned
      write_csr(CFG_FRAMES, 5'd2);
      send_request(OP_PIN, 32'h8000_0000);
      send_request(OP_UNPIN, 32'h0);
      send_request(OP_UNPIN, 32'h0);
      send_request(OP_PIN, 32'h3);
      send_request(OP_DIRTY, 32'h3);
      send_request(OP_UNPIN, 32'h8000_0000);
      send_request(OP_PIN, 32'h4);
      send_request(OP_PIN, 32'h5);
      send_request(OP_FLUSH, 32'h0);

      // pool size of zero acts as one, then LRU on the same state
      write_csr(CFG_FRAMES, 5'd0);
      send_request(OP_PIN, 32'h9);
      write_csr(CFG_POLICY, {4'd0, POLICY_LRU});
      write_csr(CFG_FRAMES, 5'd3);
      calm = 1;
      random_phase(25);
      calm = 0;
      write_csr(CFG_FRAMES, 5'd31);
      random_phase(25);
      write_csr(CFG_POLICY, {4'd0, POLICY_FIFO});
      write_csr(CFG_FRAMES, 5'd4);
      random_phase(25);
      write_csr(CFG_FRAMES, 5'd1);
      random_phase(10);
      write_csr(CFG_POLICY, {4'd0, POLICY_LRU});
      write_csr(CFG_FRAMES, 5'd16);
      random_phase(25);

      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.errors == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule
